>>> sv/rlsc_pkg.sv
// Shared types and constants of the resistive level sensor conditioner.
package rlsc_pkg;

    // Field widths
    localparam int ADC_W      = 12;
    localparam int THR_W      = 12;
    localparam int RES_W      = 20;
    localparam int LVL_W      = 7;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 20;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RES = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RES = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_RES = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FS_THR  = 8'd3;

    // Register reset values
    localparam logic [RES_W-1:0] MIN_RES_RST = 20'd0;
    localparam logic [RES_W-1:0] MAX_RES_RST = 20'd10000;
    localparam logic [RES_W-1:0] REF_RES_RST = 20'd0;
    localparam logic [THR_W-1:0] FS_THR_RST  = 12'd4083;

    // Arithmetic constants
    localparam int PROD_W    = ADC_W + RES_W;             // sample times reference
    localparam int CAL_W     = 17;
    localparam int CAL_SHIFT = 16;
    localparam int MUL_W     = PROD_W + CAL_W;
    localparam int NUM_W     = MUL_W - CAL_SHIFT;         // numerator after the Q16 drop
    localparam int HI_W      = NUM_W - RES_W;             // numerator bits above the quotient
    localparam int PCT_NUM_W = RES_W + LVL_W;

    localparam logic [CAL_W-1:0] CAL_Q16     = 17'd69992;  // 1.068 in Q16
    localparam logic [RES_W-1:0] DIRECT_SPAN = 20'd10000;
    localparam logic [RES_W-1:0] R_MAX       = 20'hFFFFF;
    localparam logic [LVL_W-1:0] PCT_SCALE   = 7'd100;
    localparam logic [LVL_W-1:0] LVL_FULL    = 7'd100;
    localparam logic [LVL_W-1:0] LVL_EMPTY   = 7'd0;

    // Quotient bits resolved per divider stage
    localparam int DIV_STEPS = 4;

    // Sideband through the resistance divider
    typedef struct packed {
        logic near;
        logic sat;
    } res_side_t;

    // Sideband through the level divider
    typedef struct packed {
        logic             near;
        logic [RES_W-1:0] res;
        logic             empty;
        logic             full;
    } lvl_side_t;

endpackage

>>> sv/rlsc_div_pipe.sv
// Pipelined restoring divider with a valid/ready handshake and a sideband word.
module rlsc_div_pipe #(
    parameter int DW    = 16,
    parameter int QW    = 20,
    parameter int SW    = 2,
    parameter int STEPS = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [DW-1:0] in_rem,   // upper numerator bits, below in_den
    input  logic [QW-1:0] in_low,   // numerator bits that become quotient bits
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [QW-1:0] out_quo,
    output logic [SW-1:0] out_side
);

    localparam int NS = (QW + STEPS - 1) / STEPS;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] stage_rdy;
    logic [DW-1:0] rem_reg  [NS];
    logic [QW-1:0] low_reg  [NS];
    logic [QW-1:0] quo_reg  [NS];
    logic [DW-1:0] den_reg  [NS];
    logic [SW-1:0] side_reg [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic          src_valid;
        logic [DW-1:0] src_rem;
        logic [QW-1:0] src_low;
        logic [QW-1:0] src_quo;
        logic [DW-1:0] src_den;
        logic [SW-1:0] src_side;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] low_next;
        logic [QW-1:0] quo_next;

        // Pick the word feeding this stage
        if (k == 0) begin : g_first
            assign src_valid = in_valid;
            assign src_rem   = in_rem;
            assign src_low   = in_low;
            assign src_quo   = '0;
            assign src_den   = in_den;
            assign src_side  = in_side;
        end else begin : g_rest
            assign src_valid = valid_reg[k-1];
            assign src_rem   = rem_reg[k-1];
            assign src_low   = low_reg[k-1];
            assign src_quo   = quo_reg[k-1];
            assign src_den   = den_reg[k-1];
            assign src_side  = side_reg[k-1];
        end

        // Stage may load when empty or when its word moves on
        if (k == NS - 1) begin : g_last_rdy
            assign stage_rdy[k] = !valid_reg[k] || out_ready;
        end else begin : g_mid_rdy
            assign stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
        end

        // Resolve up to STEPS quotient bits, MSB first
        always_comb begin
            logic [DW:0] trial;
            rem_next = src_rem;
            low_next = src_low;
            quo_next = src_quo;
            trial    = '0;
            for (int j = 0; j < STEPS; j++) begin
                if (k * STEPS + j < QW) begin
                    trial    = {rem_next, low_next[QW-1]};
                    low_next = {low_next[QW-2:0], 1'b0};
                    if (trial >= {1'b0, src_den}) begin
                        rem_next = DW'(trial - {1'b0, src_den});
                        quo_next = {quo_next[QW-2:0], 1'b1};
                    end else begin
                        rem_next = trial[DW-1:0];
                        quo_next = {quo_next[QW-2:0], 1'b0};
                    end
                end
            end
        end

        // Advance valid bit
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (stage_rdy[k]) begin
                valid_reg[k] <= src_valid;
            end
        end

        // Load payload
        always_ff @(posedge aclk) begin
            if (stage_rdy[k] && src_valid) begin
                rem_reg[k]  <= rem_next;
                low_reg[k]  <= low_next;
                quo_reg[k]  <= quo_next;
                den_reg[k]  <= src_den;
                side_reg[k] <= src_side;
            end
        end
    end

    assign in_ready  = stage_rdy[0];
    assign out_valid = valid_reg[NS-1];
    assign out_quo   = quo_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

>>> sv/resistive_level_sensor_conditioner_core.sv
// Top level: converter sample to calibrated resistance and fill level.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata[11:0] adc_sample
//  m_      | out       | m_tvalid/m_tready  | m_tdata resistance, level; m_tuser near flag
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// One word per cycle sustained while m_tready is high. The pipeline holds, in order,
// three front stages (multiply, Q16 calibrate, overflow check), five stages of the
// 20-bit resistance divider, two level stages, two stages of the 7-bit level
// divider and the output register.
// aresetn clears every valid bit and loads the register reset values.
// Each stage takes a word when it is empty or its word moves on, so a stall on
// m_tready backs up one stage at a time and bubbles are squeezed out.
module resistive_level_sensor_conditioner_core #(
    parameter int ADC_FULL_SCALE = 4095
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rlsc_pkg::S_TDATA_W-1:0]    s_tdata,    // [11:0] adc_sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rlsc_pkg::M_TDATA_W-1:0]    m_tdata,    // [19:0] resistance_ohms,
                                                          // [26:20] level_percent
    output logic                              m_tuser,    // [0] near_full_scale
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rlsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rlsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import rlsc_pkg::*;

    localparam int FS_W     = $clog2(ADC_FULL_SCALE + 1);
    localparam int CW       = (FS_W > ADC_W) ? FS_W : ADC_W;
    localparam int CMP_W    = (FS_W + RES_W > NUM_W) ? FS_W + RES_W : NUM_W;
    localparam int NS_RES   = (RES_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int NS_LVL   = (LVL_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DEPTH    = 3 + NS_RES + 2 + NS_LVL + 1;
    localparam int FLIGHT_W = $clog2(DEPTH + 1);

    // Configuration registers
    logic [RES_W-1:0] min_res_reg;
    logic [RES_W-1:0] max_res_reg;
    logic [RES_W-1:0] ref_res_reg;
    logic [THR_W-1:0] fs_thr_reg;

    assign cfg_ready = 1'b1;

    // Write configuration; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_res_reg <= MIN_RES_RST;
            max_res_reg <= MAX_RES_RST;
            ref_res_reg <= REF_RES_RST;
            fs_thr_reg  <= FS_THR_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MIN_RES: min_res_reg <= cfg_data;
                CFG_MAX_RES: max_res_reg <= cfg_data;
                CFG_REF_RES: ref_res_reg <= cfg_data;
                CFG_FS_THR:  fs_thr_reg  <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake chain
    logic v_a_reg, v_b_reg, v_c_reg, v_d_reg, v_e_reg;
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f;
    logic div_r_in_ready, div_r_out_valid;
    logic div_l_in_ready, div_l_out_valid;

    assign rdy_f    = !m_tvalid || m_tready;
    assign rdy_e    = !v_e_reg || div_l_in_ready;
    assign rdy_d    = !v_d_reg || rdy_e;
    assign rdy_c    = !v_c_reg || div_r_in_ready;
    assign rdy_b    = !v_b_reg || rdy_c;
    assign rdy_a    = !v_a_reg || rdy_b;
    assign s_tready = rdy_a;

    // Stage A: classify sample, first product, divisor
    logic [ADC_W-1:0]  sample;
    logic              direct;
    logic [RES_W-1:0]  factor;
    logic              a_near_next, a_sat_next;
    logic [PROD_W-1:0] a_prod_next;
    logic [FS_W-1:0]   a_den_next;
    logic              a_near_reg, a_sat_reg;
    logic [PROD_W-1:0] a_prod_reg;
    logic [FS_W-1:0]   a_den_reg;

    assign sample      = s_tdata[ADC_W-1:0];
    assign direct      = (ref_res_reg == '0);
    assign factor      = direct ? DIRECT_SPAN : ref_res_reg;
    assign a_near_next = (sample >= fs_thr_reg);
    assign a_sat_next  = !direct && (CW'(sample) >= CW'(ADC_FULL_SCALE));
    assign a_prod_next = PROD_W'(sample) * PROD_W'(factor);
    assign a_den_next  = direct ? FS_W'(ADC_FULL_SCALE)
                                : FS_W'(ADC_FULL_SCALE) - FS_W'(sample);

    always_ff @(posedge aclk) begin
        if (rdy_a && s_tvalid) begin
            a_near_reg <= a_near_next;
            a_sat_reg  <= a_sat_next;
            a_prod_reg <= a_prod_next;
            a_den_reg  <= a_den_next;
        end
    end

    // Stage B: apply Q16 calibration, drop the 2^16 scale of the product
    logic [MUL_W-1:0] b_mul;
    logic [NUM_W-1:0] b_num_reg;
    logic [FS_W-1:0]  b_den_reg;
    logic             b_near_reg, b_sat_reg;

    assign b_mul = MUL_W'(a_prod_reg) * MUL_W'(CAL_Q16);

    always_ff @(posedge aclk) begin
        if (rdy_b && v_a_reg) begin
            b_num_reg  <= b_mul[MUL_W-1:CAL_SHIFT];
            b_den_reg  <= a_den_reg;
            b_near_reg <= a_near_reg;
            b_sat_reg  <= a_sat_reg;
        end
    end

    // Stage C: detect quotient overflow, split numerator
    logic                  c_ovf;
    logic [HI_W+FS_W-1:0]  c_hi_ext;
    logic [FS_W-1:0]       c_rem_reg;
    logic [RES_W-1:0]      c_low_reg;
    logic [FS_W-1:0]       c_den_reg;
    res_side_t             c_side_reg;
    res_side_t             div_r_side;
    logic [RES_W-1:0]      div_r_quo;

    assign c_ovf    = CMP_W'(b_num_reg) >= CMP_W'({b_den_reg, RES_W'(0)});
    assign c_hi_ext = {FS_W'(0), b_num_reg[NUM_W-1:RES_W]};

    always_ff @(posedge aclk) begin
        if (rdy_c && v_b_reg) begin
            c_rem_reg       <= c_hi_ext[FS_W-1:0];
            c_low_reg       <= b_num_reg[RES_W-1:0];
            c_den_reg       <= b_den_reg;
            c_side_reg.near <= b_near_reg;
            c_side_reg.sat  <= b_sat_reg || c_ovf;
        end
    end

    rlsc_div_pipe #(
        .DW    (FS_W),
        .QW    (RES_W),
        .SW    ($bits(res_side_t)),
        .STEPS (DIV_STEPS)
    ) u_div_res (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v_c_reg),
        .in_ready  (div_r_in_ready),
        .in_rem    (c_rem_reg),
        .in_low    (c_low_reg),
        .in_den    (c_den_reg),
        .in_side   (c_side_reg),
        .out_valid (div_r_out_valid),
        .out_ready (rdy_d),
        .out_quo   (div_r_quo),
        .out_side  (div_r_side)
    );

    // Stage D: choose the resistance
    logic [RES_W-1:0] d_res_reg;
    logic             d_near_reg;

    always_ff @(posedge aclk) begin
        if (rdy_d && div_r_out_valid) begin
            d_near_reg <= div_r_side.near;
            if (div_r_side.near) begin
                d_res_reg <= max_res_reg;
            end else if (div_r_side.sat) begin
                d_res_reg <= R_MAX;
            end else begin
                d_res_reg <= div_r_quo;
            end
        end
    end

    // Stage E: level numerator, span and clamp cases
    logic [RES_W-1:0]     e_diff;
    logic [PCT_NUM_W-1:0] e_num;
    logic [RES_W-1:0]     e_rem_reg;
    logic [LVL_W-1:0]     e_low_reg;
    logic [RES_W-1:0]     e_den_reg;
    lvl_side_t            e_side_reg;
    lvl_side_t            div_l_side;
    logic [LVL_W-1:0]     div_l_quo;

    assign e_diff = d_res_reg - min_res_reg;
    assign e_num  = PCT_NUM_W'(e_diff) * PCT_NUM_W'(PCT_SCALE);

    always_ff @(posedge aclk) begin
        if (rdy_e && v_d_reg) begin
            e_rem_reg        <= e_num[PCT_NUM_W-1:LVL_W];
            e_low_reg        <= e_num[LVL_W-1:0];
            e_den_reg        <= max_res_reg - min_res_reg;
            e_side_reg.near  <= d_near_reg;
            e_side_reg.res   <= d_res_reg;
            e_side_reg.empty <= (max_res_reg <= min_res_reg) || (d_res_reg <= min_res_reg);
            e_side_reg.full  <= (d_res_reg >= max_res_reg);
        end
    end

    rlsc_div_pipe #(
        .DW    (RES_W),
        .QW    (LVL_W),
        .SW    ($bits(lvl_side_t)),
        .STEPS (DIV_STEPS)
    ) u_div_lvl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v_e_reg),
        .in_ready  (div_l_in_ready),
        .in_rem    (e_rem_reg),
        .in_low    (e_low_reg),
        .in_den    (e_den_reg),
        .in_side   (e_side_reg),
        .out_valid (div_l_out_valid),
        .out_ready (rdy_f),
        .out_quo   (div_l_quo),
        .out_side  (div_l_side)
    );

    // Stage F: clamp level, hold the output word
    logic [LVL_W-1:0] f_lvl;
    logic             m_tvalid_reg;
    logic [RES_W-1:0] m_res_reg;
    logic [LVL_W-1:0] m_lvl_reg;
    logic             m_near_reg;

    assign f_lvl = div_l_side.empty ? LVL_EMPTY :
                   div_l_side.full  ? LVL_FULL  : div_l_quo;

    always_ff @(posedge aclk) begin
        if (rdy_f && div_l_out_valid) begin
            m_res_reg  <= div_l_side.res;
            m_lvl_reg  <= f_lvl;
            m_near_reg <= div_l_side.near;
        end
    end

    // Advance valid bits of the top-level stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_a_reg      <= 1'b0;
            v_b_reg      <= 1'b0;
            v_c_reg      <= 1'b0;
            v_d_reg      <= 1'b0;
            v_e_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (rdy_a) v_a_reg <= s_tvalid;
            if (rdy_b) v_b_reg <= v_a_reg;
            if (rdy_c) v_c_reg <= v_b_reg;
            if (rdy_d) v_d_reg <= div_r_out_valid;
            if (rdy_e) v_e_reg <= v_d_reg;
            if (rdy_f) m_tvalid_reg <= div_l_out_valid;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - LVL_W - RES_W)'(0), m_lvl_reg, m_res_reg};
    assign m_tuser  = m_near_reg;

    // Count words in flight
    logic [FLIGHT_W-1:0] flight_reg;
    logic [FLIGHT_W-1:0] flight_next;

    assign flight_next = flight_reg + FLIGHT_W'(s_tvalid && s_tready)
                                    - FLIGHT_W'(m_tvalid && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flight_reg <= '0;
        end else begin
            flight_reg <= flight_next;
        end
    end

    // Checks
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[RES_W +: LVL_W] <= LVL_FULL))
        else $error("level above full scale");

    a_front_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v_a_reg && v_b_reg && v_c_reg && !div_r_in_ready))
        else $error("input stalled with a free front stage");

    a_flight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        flight_reg <= FLIGHT_W'(DEPTH))
        else $error("more words in flight than stages");

    a_empty_no_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (flight_reg == '0) |-> !m_tvalid)
        else $error("output word with nothing in flight");

endmodule
